/* design/c2p_pkg.sv */
// ----------------------------------------------------------------------------
// c2p_pkg - shared constants for the cartesian to polar core
// angle table, gain and rounding constants, output formats
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package c2p_pkg;

    // fixed output formats
    localparam int MAG_W      = 24;
    localparam int ANG_W      = 16;

    // internal formats
    localparam int GUARD_BITS = 12;
    localparam int Z_W        = 24;    // angle accumulator, q.20 radians
    localparam int ANG_FRAC   = 20;
    localparam int ANG_OUT_FRAC = 13;
    localparam int TABLE_LEN  = 24;

    localparam int GAIN_W     = 16;
    localparam logic [GAIN_W-1:0] GAIN_Q16 = 16'd39797;

    localparam logic signed [Z_W-1:0] PI_Q20 = 24'sd3294199;
    localparam logic signed [Z_W-1:0] ANG_ROUND = 24'sd64;

    localparam logic [MAG_W-1:0] MAG_MAX = 24'hFFFFFF;
    localparam int ANG_LIMIT  = 25736;

    // round(atan(2^-i) * 2^20)
    function automatic logic signed [Z_W-1:0] atan_q20(input int i);
        logic signed [Z_W-1:0] v;
        unique case (i)
            0:       v = 24'sd823550;
            1:       v = 24'sd486170;
            2:       v = 24'sd256879;
            3:       v = 24'sd130396;
            4:       v = 24'sd65451;
            5:       v = 24'sd32757;
            6:       v = 24'sd16383;
            7:       v = 24'sd8192;
            8:       v = 24'sd4096;
            9:       v = 24'sd2048;
            10:      v = 24'sd1024;
            11:      v = 24'sd512;
            12:      v = 24'sd256;
            13:      v = 24'sd128;
            14:      v = 24'sd64;
            15:      v = 24'sd32;
            16:      v = 24'sd16;
            17:      v = 24'sd8;
            18:      v = 24'sd4;
            19:      v = 24'sd2;
            20:      v = 24'sd1;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

endpackage

/* design/cartesian_to_polar_core.sv */
// ----------------------------------------------------------------------------
// cartesian_to_polar_core - pipelined cordic vectoring, (x, y) to (mag, angle)
// throughput: one item per cycle while out_stall is low; the pipeline is one
//   prep stage, one register per cordic micro-rotation, a split gain multiply
//   and a final add/saturate
// a stalled output holds only the stages behind it that are full; empty
//   stages keep filling, so in_stall rises only when every stage holds an item
// reset clears the stage valid bits only; data registers are not reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cartesian_to_polar_core
    import c2p_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int STAGES      = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [COORD_WIDTH-1:0] x_coord,
    input  logic signed [COORD_WIDTH-1:0] y_coord,
    input  logic                          in_valid,
    output logic                          in_stall,
    output logic        [MAG_W-1:0]       magnitude,
    output logic signed [ANG_W-1:0]       angle,
    output logic                          out_valid,
    input  logic                          out_stall
);

    // internal x/y width: input, guard bits, room for negation and cordic gain
    localparam int IW     = COORD_WIDTH + GUARD_BITS + 3;
    localparam int XU_W   = IW - 1;
    localparam int LO_W   = IW / 2;
    localparam int HI_W   = XU_W - LO_W;
    localparam int LO_P   = LO_W + GAIN_W;
    localparam int HI_P   = HI_W + GAIN_W;
    localparam int SUM_W  = XU_W + GAIN_W + 1;
    localparam int MF_W   = SUM_W - ANG_FRAC;
    // stage numbering: 0 prep, 1..STAGES cordic, STAGES+1 multiply, last output
    localparam int MUL_S  = STAGES + 1;
    localparam int NSTG   = STAGES + 3;
    localparam int OUT_S  = NSTG - 1;
    localparam logic [SUM_W-1:0] MAG_ROUND = SUM_W'(1) << (ANG_FRAC - 1);

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] rdy;

    logic signed [IW-1:0]  x_reg    [0:STAGES];
    logic signed [IW-1:0]  y_reg    [0:STAGES];
    logic signed [Z_W-1:0] z_reg    [0:STAGES];
    logic                  zero_reg [0:MUL_S];

    logic [LO_P-1:0]         lo_reg;
    logic [HI_P-1:0]         hi_reg;
    logic signed [ANG_W-1:0] ang_reg;
    logic [MAG_W-1:0]        magnitude_reg;
    logic signed [ANG_W-1:0] angle_reg;

    // ready chain: a stage loads when it is empty or the stage after it loads
    assign rdy[OUT_S] = !vld_reg[OUT_S] || !out_stall;
    generate
        for (genvar k = 0; k < OUT_S; k++) begin : g_rdy
            assign rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    endgenerate

    assign in_stall  = !rdy[0];
    assign out_valid = vld_reg[OUT_S];
    assign magnitude = magnitude_reg;
    assign angle     = angle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // prep stage: scale by guard bits, fold the left half plane by pi
    logic signed [IW-1:0]  x_in, y_in;
    logic signed [IW-1:0]  x0_next, y0_next;
    logic signed [Z_W-1:0] z0_next;
    logic                  zero0_next;

    always_comb
    begin
        x_in = {{3{x_coord[COORD_WIDTH-1]}}, x_coord, {GUARD_BITS{1'b0}}};
        y_in = {{3{y_coord[COORD_WIDTH-1]}}, y_coord, {GUARD_BITS{1'b0}}};
        zero0_next = (x_coord == '0) && (y_coord == '0);
        if (x_in[IW-1])
        begin
            x0_next = -x_in;
            y0_next = -y_in;
            z0_next = y_in[IW-1] ? -PI_Q20 : PI_Q20;
        end
        else
        begin
            x0_next = x_in;
            y0_next = y_in;
            z0_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            x_reg[0]    <= x0_next;
            y_reg[0]    <= y0_next;
            z_reg[0]    <= z0_next;
            zero_reg[0] <= zero0_next;
        end
    end

    // one micro-rotation per stage, driving y toward zero
    generate
        for (genvar k = 0; k < STAGES; k++) begin : g_cordic
            logic signed [IW-1:0]  xs, ys;
            logic signed [IW-1:0]  x_next, y_next;
            logic signed [Z_W-1:0] z_next;

            always_comb
            begin
                xs = x_reg[k] >>> k;
                ys = y_reg[k] >>> k;
                if (!y_reg[k][IW-1])
                begin
                    x_next = x_reg[k] + ys;
                    y_next = y_reg[k] - xs;
                    z_next = z_reg[k] + atan_q20(k);
                end
                else
                begin
                    x_next = x_reg[k] - ys;
                    y_next = y_reg[k] + xs;
                    z_next = z_reg[k] - atan_q20(k);
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[k+1])
                begin
                    x_reg[k+1]    <= x_next;
                    y_reg[k+1]    <= y_next;
                    z_reg[k+1]    <= z_next;
                    zero_reg[k+1] <= zero_reg[k];
                end
            end
        end
    endgenerate

    // multiply stage: gain compensation split in two partial products,
    // angle rounded to q3.13 and clamped
    logic [XU_W-1:0]         xu;
    logic [LO_P-1:0]         lo_next;
    logic [HI_P-1:0]         hi_next;
    logic signed [Z_W-1:0]   z_rnd, z_sh;
    logic signed [ANG_W-1:0] ang_next;

    always_comb
    begin
        xu      = x_reg[STAGES][IW-1] ? '0 : x_reg[STAGES][XU_W-1:0];
        lo_next = LO_P'(xu[LO_W-1:0]) * LO_P'(GAIN_Q16);
        hi_next = HI_P'(xu[XU_W-1:LO_W]) * HI_P'(GAIN_Q16);
        z_rnd   = z_reg[STAGES] + ANG_ROUND;
        z_sh    = z_rnd >>> (ANG_FRAC - ANG_OUT_FRAC);
        if (zero_reg[STAGES])
        begin
            ang_next = '0;
        end
        else if (z_sh > Z_W'(ANG_LIMIT))
        begin
            ang_next = ANG_W'(ANG_LIMIT);
        end
        else if (z_sh < Z_W'(-ANG_LIMIT))
        begin
            ang_next = ANG_W'(-ANG_LIMIT);
        end
        else
        begin
            ang_next = z_sh[ANG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[MUL_S])
        begin
            lo_reg          <= lo_next;
            hi_reg          <= hi_next;
            ang_reg         <= ang_next;
            zero_reg[MUL_S] <= zero_reg[STAGES];
        end
    end

    // output stage: join partial products, round to 8 fraction bits, saturate
    logic [SUM_W-1:0] mag_sum;
    logic [MF_W-1:0]  mag_full;
    logic [63:0]      mag_wide;
    logic [MAG_W-1:0] magnitude_next;

    always_comb
    begin
        mag_sum  = (SUM_W'(hi_reg) << LO_W) + SUM_W'(lo_reg) + MAG_ROUND;
        mag_full = mag_sum[SUM_W-1:ANG_FRAC];
        mag_wide = 64'(mag_full);
        if (zero_reg[MUL_S])
        begin
            magnitude_next = '0;
        end
        else if (mag_wide > 64'(MAG_MAX))
        begin
            magnitude_next = MAG_MAX;
        end
        else
        begin
            magnitude_next = mag_wide[MAG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[OUT_S])
        begin
            magnitude_reg <= magnitude_next;
            angle_reg     <= ang_reg;
        end
    end

`ifndef SYNTHESIS
    // input stalls only when every stage holds an item
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (vld_reg == {NSTG{1'b1}}))
        else $error("input stalled with an empty stage");

    // a free output lets the whole pipeline move
    a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output is free");

    // an accepted item lands in the prep stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld_reg[0])
        else $error("accepted item lost at prep stage");

    // angle stays within plus or minus pi
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((angle <= ANG_W'(ANG_LIMIT)) && (angle >= ANG_W'(-ANG_LIMIT))))
        else $error("angle out of range");
`endif

endmodule

/* tb/cartesian_to_polar_core_test.sv */
// ----------------------------------------------------------------------------
// cartesian_to_polar_core_test - self-checking bench for the cordic core
// drives signed points through the valid/stall handshake with random gaps
// and output stalls, predicts magnitude and angle per point with a bit-exact
// fixed-point cordic model and compares every result in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import c2p_pkg::*;

typedef logic signed [15:0] coord_t;

class polar_scoreboard;

    typedef struct {
        coord_t                  x;
        coord_t                  y;
        logic        [MAG_W-1:0] mag;
        logic signed [ANG_W-1:0] ang;
    } polar_t;

    polar_t pending_polar[$];
    longint atan_step[24];
    int     n_stages;
    int     errors;

    function new(int stages);
        n_stages  = stages;
        errors    = 0;
        // atan(2^-i) in q.20 radians
        atan_step = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                      4096, 2048, 1024, 512, 256, 128, 64, 32,
                      16, 8, 4, 2, 1, 0, 0, 0};
    endfunction

    task report(string what);
        if (errors < 40)
            $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    // run the vectoring iterations for an accepted point and queue the result
    function void note_point(coord_t xv, coord_t yv);
        polar_t r;
        longint px;
        longint py;
        longint pz;
        longint sx;
        longint sy;
        longint rmag;
        longint rang;
        r.x   = xv;
        r.y   = yv;
        r.mag = '0;
        r.ang = '0;
        if (xv != 0 || yv != 0)
        begin
            px = longint'(xv) * 4096;
            py = longint'(yv) * 4096;
            pz = 0;
            // left half plane: rotate by pi first
            if (px < 0)
            begin
                pz = (py >= 0) ? 64'sd3294199 : -64'sd3294199;
                px = -px;
                py = -py;
            end
            for (int i = 0; i < n_stages && i < 24; i++)
            begin
                sx = px >>> i;
                sy = py >>> i;
                if (py >= 0)
                begin
                    px = px + sy;
                    py = py - sx;
                    pz = pz + atan_step[i];
                end
                else
                begin
                    px = px - sy;
                    py = py + sx;
                    pz = pz - atan_step[i];
                end
            end
            if (px < 0)
                px = 0;
            rmag = (px * 39797 + 64'sd524288) >>> 20;
            if (rmag > 64'sd16777215)
                rmag = 64'sd16777215;
            rang = (pz + 64) >>> 7;
            if (rang > 64'sd25736)
                rang = 64'sd25736;
            if (rang < -64'sd25736)
                rang = -64'sd25736;
            r.mag = rmag[MAG_W-1:0];
            r.ang = rang[ANG_W-1:0];
        end
        pending_polar.push_back(r);
    endfunction

    task check_result(logic [MAG_W-1:0] mag, logic signed [ANG_W-1:0] ang);
        polar_t want;
        if (pending_polar.size() == 0)
        begin
            report($sformatf("result with no point pending: mag %0d angle %0d", mag, ang));
            return;
        end
        want = pending_polar.pop_front();
        if (mag !== want.mag)
            report($sformatf("point (%0d,%0d) magnitude %0d, want %0d",
                             want.x, want.y, mag, want.mag));
        if (ang !== want.ang)
            report($sformatf("point (%0d,%0d) angle %0d, want %0d",
                             want.x, want.y, ang, want.ang));
    endtask

endclass

module cartesian_to_polar_core_test;

    localparam int COORD_WIDTH    = 16;
    localparam int STAGES         = 16;
    localparam int RANDOM_POINTS  = 600;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                    clk;
    logic                    rst_n     = 1'b0;
    coord_t                  x_coord   = '0;
    coord_t                  y_coord   = '0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    logic        [MAG_W-1:0] magnitude;
    logic signed [ANG_W-1:0] angle;
    logic                    out_valid;
    logic                    out_stall = 1'b0;

    polar_scoreboard sb;
    bit              no_idle = 1'b0;
    int              idle_cycles = 0;

    cartesian_to_polar_core #(
        .COORD_WIDTH (COORD_WIDTH),
        .STAGES      (STAGES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .magnitude (magnitude),
        .angle     (angle),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // both handshakes are sampled before the edge updates take effect
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_point(x_coord, y_coord);
            if (out_valid && !out_stall)
                sb.check_result(magnitude, angle);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("cartesian_to_polar_core_test: errors");
            $finish;
        end
    end

    // output side: random stall before each result
    initial
    begin
        int stall_len;
        forever
        begin
            stall_len = no_idle ? 0 : $urandom_range(0, 12);
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(rst_n && out_valid && !out_stall));
        end
    end

    task automatic send_point(input coord_t xv, input coord_t yv);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        x_coord  <= xv;
        y_coord  <= yv;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_polar.size() != 0)
            @(posedge clk);
    endtask

    function automatic coord_t random_coord(int kind);
        logic [31:0] r;
        coord_t      v;
        r = $urandom;
        case (kind)
            0:       v = r[15:0];
            1:       v = 16'(int'($urandom_range(0, 16)) - 8);
            2:       v = 16'(int'($urandom_range(0, 512)) - 256);
            default:
            begin
                case ($urandom_range(0, 4))
                    0:       v = 16'sh8000;
                    1:       v = 16'sh7fff;
                    2:       v = -16'sd1;
                    3:       v = 16'sd1;
                    default: v = 16'sd0;
                endcase
            end
        endcase
        return v;
    endfunction

    initial
    begin
        int     kind;
        coord_t xv;
        coord_t yv;
        sb = new(STAGES);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // origin, corners, axis points and the points next to +-pi
        send_point(16'sd0, 16'sd0);
        send_point(16'sh7fff, 16'sh7fff);
        send_point(16'sh8000, 16'sh8000);
        send_point(16'sh8000, 16'sh7fff);
        send_point(16'sh7fff, 16'sh8000);
        send_point(16'sh7fff, 16'sd0);
        send_point(16'sh8000, 16'sd0);
        send_point(16'sd0, 16'sh7fff);
        send_point(16'sd0, 16'sh8000);
        send_point(16'sd1, 16'sd0);
        send_point(-16'sd1, 16'sd0);
        send_point(16'sd0, 16'sd1);
        send_point(16'sd0, -16'sd1);
        send_point(-16'sd1, -16'sd1);
        send_point(-16'sd1, 16'sd1);
        send_point(16'sd1, -16'sd1);
        send_point(16'sh8000, 16'sd1);
        send_point(16'sh8000, -16'sd1);
        send_point(16'sh8001, 16'sd0);
        send_point(16'sh5555, 16'shaaaa);
        send_point(16'shaaaa, 16'sh5555);
        send_point(16'sd0, 16'sd0);

        // hold off until the pipeline is empty
        drain_results();

        for (int n = 0; n < RANDOM_POINTS; n++)
        begin
            no_idle = (n % 150) < 40;
            if (n == RANDOM_POINTS / 2)
                drain_results();
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3:
                begin
                    xv = random_coord(0);
                    yv = random_coord(0);
                end
                4:
                begin
                    xv = random_coord(1);
                    yv = random_coord(1);
                end
                5:
                begin
                    xv = random_coord(2);
                    yv = random_coord(2);
                end
                6:
                begin
                    // on an axis
                    xv = random_coord(0);
                    yv = '0;
                    if ($urandom_range(0, 1) == 1)
                    begin
                        yv = xv;
                        xv = '0;
                    end
                end
                7:
                begin
                    // just off the negative x axis, where the angle wraps
                    xv = -16'($urandom_range(1, 32768));
                    yv = random_coord(1);
                end
                default:
                begin
                    xv = random_coord(3);
                    yv = random_coord(3);
                end
            endcase
            send_point(xv, yv);
        end

        no_idle = 1'b0;
        drain_results();
        repeat (STAGES + 13) @(posedge clk);
        if (sb.errors == 0)
            $display("cartesian_to_polar_core_test: clean");
        else
            $display("cartesian_to_polar_core_test: errors");
        $finish;
    end

endmodule
